>>> rtl/core/dfs_pkg.sv
// Package for the delimited field splitter: payload types, codes and defaults.
package dfs_pkg;

  // Default configuration of the block.
  localparam int DEF_MAX_COLUMNS  = 32;
  localparam int DEF_OFFSET_WIDTH = 32;

  // Fixed widths of the result fields.
  localparam int COL_W = 5;
  localparam int IDX_W = 6;
  localparam int POS_W = 32;

  // Result kinds.
  localparam logic [1:0] KIND_SPAN    = 2'd0;
  localparam logic [1:0] KIND_MISSING = 2'd1;
  localparam logic [1:0] KIND_DROPPED = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_SEPARATOR = 2'd0;
  localparam logic [1:0] REG_EOL       = 2'd1;
  localparam logic [1:0] REG_QUOTE     = 2'd2;

  // Register reset values.
  localparam logic [7:0] RST_SEPARATOR = 8'd44;
  localparam logic [7:0] RST_EOL       = 8'd10;
  localparam logic [7:0] RST_QUOTE     = 8'd34;

  // Results of one byte are limited during a fill pass.
  localparam logic [IDX_W-1:0] FILL_LIMIT = 6'd32;
  localparam logic [IDX_W-1:0] COL_MAX    = 6'd31;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_final;
  } in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [COL_W-1:0] column;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] span_start;
    logic [POS_W-1:0] span_end;
    logic             was_quoted;
    logic             opens_column;
    logic             last_of_run;
  } out_t;

endpackage

>>> rtl/core/delimited_field_splitter.sv
// Delimited text splitter: per-byte sequencer that emits field, missing and dropped results.
// A byte that yields no result goes from the final check to the done step; a last byte
// also passes the clear step. One close or fill step is added per result, and one step ends
// each fill pass. One byte is in flight at a time; output back-pressure stretches the emit
// steps. Results leave through a holding stage and an output register, so the last result of
// a byte may still wait at the output while the next byte is accepted.
// Reset: synchronous, active low; clears the parse state and restores the register defaults.
module delimited_field_splitter
  import dfs_pkg::*;
#(
  parameter int MAX_COLUMNS  = DEF_MAX_COLUMNS,
  parameter int OFFSET_WIDTH = DEF_OFFSET_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int OFS_W = (OFFSET_WIDTH < 32) ? OFFSET_WIDTH : 32;
  localparam logic [IDX_W-1:0] CAP = IDX_W'((MAX_COLUMNS < 32) ? MAX_COLUMNS : 32);
  localparam logic [OFS_W-1:0] OFS_LIM = {OFS_W{1'b1}};

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLOSE  = 3'd1;
  localparam logic [2:0] S_FILL   = 3'd2;
  localparam logic [2:0] S_FINCHK = 3'd3;
  localparam logic [2:0] S_CLEAR  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  // What caused the current close or fill.
  localparam logic [1:0] PH_SEP = 2'd0;
  localparam logic [1:0] PH_EOL = 2'd1;
  localparam logic [1:0] PH_FIN = 2'd2;

  logic [7:0]       sep_r, sep_nxt, eol_r, eol_nxt, quo_r, quo_nxt;
  logic             inq_r, inq_nxt, esc_r, esc_nxt;
  logic [OFS_W-1:0] ofs_r, ofs_nxt, fb_r, fb_nxt, here_r, here_nxt;
  logic [IDX_W-1:0] ci_r, ci_nxt, ct_r, ct_nxt, n_r, n_nxt;
  logic [POS_W-1:0] row_r, row_nxt;
  logic [2:0]       state_r, state_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             fin_r, fin_nxt, opens_r, opens_nxt;
  logic             pend_v_r, pend_v_nxt, out_v_r, out_v_nxt;
  out_t             pend_r, pend_nxt, out_r, out_nxt;

  logic             out_free, slot_free, out_load;
  logic [COL_W-1:0] col_sat;
  logic [IDX_W-1:0] ci_inc, after;
  logic [OFS_W-1:0] ofs_inc;
  logic [7:0]       c;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Shared helpers of the acceptance and emit steps.
  assign out_free  = !out_v_r || out_ready;
  assign slot_free = !pend_v_r || out_free;
  assign col_sat   = (ci_r > COL_MAX) ? COL_MAX[COL_W-1:0] : ci_r[COL_W-1:0];
  assign ci_inc    = (ci_r < CAP) ? ci_r + 6'd1 : ci_r;
  assign after     = (ci_r < CAP) ? ci_r + 6'd1 : CAP;
  assign ofs_inc   = (ofs_r == OFS_LIM) ? ofs_r : ofs_r + {{(OFS_W-1){1'b0}}, 1'b1};
  assign c         = in_data.data_byte;

  // Sequencer, parse state and result staging.
  always_comb begin
    sep_nxt    = sep_r;
    eol_nxt    = eol_r;
    quo_nxt    = quo_r;
    inq_nxt    = inq_r;
    esc_nxt    = esc_r;
    ofs_nxt    = ofs_r;
    fb_nxt     = fb_r;
    here_nxt   = here_r;
    ci_nxt     = ci_r;
    ct_nxt     = ct_r;
    n_nxt      = n_r;
    row_nxt    = row_r;
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    fin_nxt    = fin_r;
    opens_nxt  = opens_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_nxt    = out_r;
    out_load   = 1'b0;

    // Configuration writes.
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SEPARATOR: sep_nxt = cfg_data;
        REG_EOL:       eol_nxt = cfg_data;
        REG_QUOTE:     quo_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          here_nxt  = ofs_r;
          ofs_nxt   = ofs_inc;
          fin_nxt   = in_data.is_final;
          n_nxt     = '0;
          opens_nxt = 1'b0;
          state_nxt = S_FINCHK;
          priority if (inq_r) begin
            if (c == quo_r) begin
              inq_nxt = 1'b0;
            end
          end else if (c == eol_r) begin
            phase_nxt = PH_EOL;
            state_nxt = S_CLOSE;
          end else if (c == sep_r) begin
            if (after >= ct_r && ct_r < CAP) begin
              ct_nxt    = ct_r + 6'd1;
              opens_nxt = 1'b1;
            end
            phase_nxt = PH_SEP;
            state_nxt = S_CLOSE;
          end else if (c == quo_r) begin
            esc_nxt = 1'b1;
            inq_nxt = 1'b1;
          end else begin
          end
        end
      end
      S_CLOSE: begin
        if (slot_free) begin
          if (pend_v_r) begin
            out_load = 1'b1;
            out_nxt  = pend_r;
          end
          pend_v_nxt          = 1'b1;
          pend_nxt.kind       = (ci_r >= CAP) ? KIND_DROPPED : KIND_SPAN;
          pend_nxt.column     = col_sat;
          pend_nxt.row        = row_r;
          pend_nxt.span_start = POS_W'(fb_r);
          pend_nxt.span_end   = (phase_r == PH_FIN) ? POS_W'(ofs_r) : POS_W'(here_r);
          pend_nxt.was_quoted   = esc_r;
          pend_nxt.opens_column = opens_r;
          pend_nxt.last_of_run  = 1'b0;
          ci_nxt  = ci_inc;
          esc_nxt = 1'b0;
          n_nxt   = n_r + 6'd1;
          if (phase_r == PH_SEP) begin
            fb_nxt    = ofs_r;
            state_nxt = S_FINCHK;
          end else begin
            state_nxt = S_FILL;
          end
        end
      end
      S_FILL: begin
        if (ci_r < ct_r && n_r < FILL_LIMIT) begin
          if (slot_free) begin
            if (pend_v_r) begin
              out_load = 1'b1;
              out_nxt  = pend_r;
            end
            pend_v_nxt            = 1'b1;
            pend_nxt.kind         = KIND_MISSING;
            pend_nxt.column       = col_sat;
            pend_nxt.row          = row_r;
            pend_nxt.span_start   = '0;
            pend_nxt.span_end     = '0;
            pend_nxt.was_quoted   = 1'b0;
            pend_nxt.opens_column = 1'b0;
            pend_nxt.last_of_run  = 1'b0;
            ci_nxt = ci_r + 6'd1;
            n_nxt  = n_r + 6'd1;
          end
        end else if (phase_r == PH_EOL) begin
          ci_nxt    = '0;
          row_nxt   = (row_r == {POS_W{1'b1}}) ? row_r : row_r + 32'd1;
          fb_nxt    = ofs_r;
          state_nxt = S_FINCHK;
        end else begin
          state_nxt = S_CLEAR;
        end
      end
      S_FINCHK: begin
        // At the last byte, flush an open field and fill the rest of the row.
        if (!fin_r) begin
          state_nxt = S_DONE;
        end else if (fb_r < ofs_r || (fb_r == ofs_r && ofs_r == here_r)) begin
          phase_nxt = PH_FIN;
          opens_nxt = 1'b0;
          state_nxt = S_CLOSE;
        end else if (ci_r != '0) begin
          phase_nxt = PH_FIN;
          state_nxt = S_FILL;
        end else begin
          state_nxt = S_CLEAR;
        end
      end
      S_CLEAR: begin
        inq_nxt   = 1'b0;
        esc_nxt   = 1'b0;
        ofs_nxt   = '0;
        fb_nxt    = '0;
        ci_nxt    = '0;
        ct_nxt    = 6'd1;
        row_nxt   = '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // The held result is the last one of this byte.
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_load             = 1'b1;
          out_nxt              = pend_r;
          out_nxt.last_of_run  = 1'b1;
          pend_v_nxt           = 1'b0;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Output register holds a transaction until it is taken.
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r    <= RST_SEPARATOR;
      eol_r    <= RST_EOL;
      quo_r    <= RST_QUOTE;
      inq_r    <= 1'b0;
      esc_r    <= 1'b0;
      ofs_r    <= '0;
      fb_r     <= '0;
      here_r   <= '0;
      ci_r     <= '0;
      ct_r     <= 6'd1;
      n_r      <= '0;
      row_r    <= '0;
      state_r  <= S_IDLE;
      phase_r  <= PH_SEP;
      fin_r    <= 1'b0;
      opens_r  <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      sep_r    <= sep_nxt;
      eol_r    <= eol_nxt;
      quo_r    <= quo_nxt;
      inq_r    <= inq_nxt;
      esc_r    <= esc_nxt;
      ofs_r    <= ofs_nxt;
      fb_r     <= fb_nxt;
      here_r   <= here_nxt;
      ci_r     <= ci_nxt;
      ct_r     <= ct_nxt;
      n_r      <= n_nxt;
      row_r    <= row_nxt;
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      fin_r    <= fin_nxt;
      opens_r  <= opens_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  // A new byte never finds a result still held from the previous one.
  a_no_pend_at_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !pend_v_r)
    else $error("held result present when a byte was accepted");

  // Column counters stay within the cap.
  a_col_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    ci_r <= CAP && ct_r >= 6'd1 && ct_r <= CAP)
    else $error("column counters out of range");

  // A transaction marked as last comes only from the end of a byte.
  a_last_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && out_nxt.last_of_run |-> state_r == S_DONE)
    else $error("last result marked outside the end of a byte");

  // An accepted byte always takes the sequencer out of idle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("sequencer idle right after acceptance");

endmodule
